### rtl/dpp_pkg.sv
// ----------------------------------------------------------------------------
// dpp_pkg
// Shared types and constants for the depth pixel to point pipeline.
// ----------------------------------------------------------------------------
package dpp_pkg;

  localparam int GRID_STEP      = 1;
  localparam int INVALID_SAMPLE = 0;
  localparam int COORD_BITS     = 12;

  localparam logic [11:0] COORD_MASK = 12'((33'd1 << COORD_BITS) - 33'd1);
  // ceil(2^32 / stride): exact quotient for coordinates below 2^16
  localparam logic [32:0] STRIDE_RECIP =
    33'(((64'd1 << 32) + 64'(GRID_STEP) - 64'd1) / 64'(GRID_STEP));

  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 32;

  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 32;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_INV_FOCAL_X    = 3'd0,
    REG_INV_FOCAL_Y    = 3'd1,
    REG_CENTER_X       = 3'd2,
    REG_CENTER_Y       = 3'd3,
    REG_DEPTH_SCALE    = 3'd4,
    REG_MIN_RANGE      = 3'd5,
    REG_MAX_RANGE      = 3'd6,
    REG_RAY_RANGE_MODE = 3'd7
  } cfg_reg_t;

  localparam logic [31:0] RST_INV_FOCAL_X = 32'd27962;
  localparam logic [31:0] RST_INV_FOCAL_Y = 32'd27962;
  localparam logic [15:0] RST_CENTER_X    = 16'd5120;
  localparam logic [15:0] RST_CENTER_Y    = 16'd3840;
  localparam logic [31:0] RST_DEPTH_SCALE = 32'd4294967;
  localparam logic [31:0] RST_MIN_RANGE   = 32'd0;
  localparam logic [31:0] RST_MAX_RANGE   = 32'd655360;

  typedef struct packed {
    logic [11:0] column;
    logic [11:0] row;
    logic [15:0] depth_sample;
  } pixel_t;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
  } point_t;

endpackage

### rtl/dpp_sqrt.sv
// ----------------------------------------------------------------------------
// dpp_sqrt
// Pipelined 64-bit integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module dpp_sqrt (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] rad,
  output logic [31:0] root
);
  import dpp_pkg::*;

  logic [63:0] x   [SQRT_STEPS];
  logic [63:0] res [SQRT_STEPS];

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
    localparam logic [63:0] BIT = 64'd1 << (2 * (SQRT_STEPS - 1 - k));
    logic [63:0] x_in;
    logic [63:0] res_in;
    logic [63:0] trial;
    logic        ge;

    if (k == 0) begin : g_first
      assign x_in   = rad;
      assign res_in = '0;
    end else begin : g_next
      assign x_in   = x[k-1];
      assign res_in = res[k-1];
    end

    assign trial = res_in + BIT;
    assign ge    = x_in >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        x[k]   <= ge ? x_in - trial : x_in;
        res[k] <= ge ? (res_in >> 1) + BIT : res_in >> 1;
      end
    end
  end

  assign root = res[SQRT_STEPS-1][31:0];

endmodule

### rtl/dpp_div.sv
// ----------------------------------------------------------------------------
// dpp_div
// Pipelined restoring divider, 64-bit dividend by 33-bit divisor, one
// quotient bit per stage. Quotient must fit in 32 bits.
// ----------------------------------------------------------------------------
module dpp_div (
  input  logic                          clk,
  input  logic                          en,
  input  logic [63:0]                   num,
  input  logic [32:0]                   den,
  output logic [dpp_pkg::DIV_STEPS-1:0] quo
);
  import dpp_pkg::*;

  logic [32:0]          rem [DIV_STEPS];
  logic [DIV_STEPS-1:0] lo  [DIV_STEPS];
  logic [32:0]          dv  [DIV_STEPS];

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic [32:0]          rem_in;
    logic [DIV_STEPS-1:0] lo_in;
    logic [32:0]          dv_in;
    logic [33:0]          trial;
    logic                 ge;

    if (k == 0) begin : g_first
      assign rem_in = {1'b0, num[63:32]};
      assign lo_in  = num[DIV_STEPS-1:0];
      assign dv_in  = den;
    end else begin : g_next
      assign rem_in = rem[k-1];
      assign lo_in  = lo[k-1];
      assign dv_in  = dv[k-1];
    end

    assign trial = {rem_in, lo_in[DIV_STEPS-1]};
    assign ge    = trial >= {1'b0, dv_in};

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k] <= ge ? 33'(trial - {1'b0, dv_in}) : trial[32:0];
        lo[k]  <= {lo_in[DIV_STEPS-2:0], ge};
        dv[k]  <= dv_in;
      end
    end
  end

  assign quo = lo[DIV_STEPS-1];

endmodule

### rtl/depth_pixel_to_point.sv
// ----------------------------------------------------------------------------
// depth_pixel_to_point
// Pinhole deprojection of depth pixels into colored camera-frame points.
// ----------------------------------------------------------------------------
// Usage:
//   pixel channel (valid/ready) carries column, row and raw depth sample.
//   point channel (valid/ready) carries x, y, z in Q16.16 meters and a
//   ramp color. Pixels off the stride grid, with the invalid code, zero
//   depth or a range outside min..max produce no point.
//   Config: cfg_we writes cfg_data into register cfg_index. The user must
//   write only while idle; the block itself does not enforce this.
// Timing: fully pipelined, one pixel per cycle when not stalled.
//   From accept to point valid a pixel passes 5 front stages, two
//   32-stage square roots, two 32-stage divider banks and 6 stages of
//   select, range and output. Both modes run at the same rate.
// Reset: rst (sync) empties the pipeline and loads the default camera.
// Stall: while a point waits on the output the whole pipeline holds and
//   pixel_ready is low; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module depth_pixel_to_point (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  pixel_valid,
  output logic                                  pixel_ready,
  input  dpp_pkg::pixel_t                       pixel,
  output logic                                  point_valid,
  input  logic                                  point_ready,
  output dpp_pkg::point_t                       point,
  input  logic                                  cfg_we,
  input  logic [dpp_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [dpp_pkg::CFG_DATA_BITS-1:0]     cfg_data
);
  import dpp_pkg::*;

  typedef struct packed {
    logic [62:0] rxd;
    logic [62:0] ryd;
    logic [31:0] d;
    logic [46:0] xz;
    logic [46:0] yz;
    logic        xn;
    logic        yn;
  } side_a_t;

  typedef struct packed {
    logic [31:0] d;
    logic [46:0] xz;
    logic [46:0] yz;
    logic        xn;
    logic        yn;
  } side_b_t;

  typedef struct packed {
    logic [31:0] xb;
    logic [31:0] yb;
    logic [31:0] zb;
  } coord_t;

  function automatic logic [63:0] sat_coord(input logic [47:0] mag, input logic neg);
    logic [31:0] m;
    logic        ng;
    ng = neg && (mag != 48'd0);
    if (ng) begin
      m = (mag > 48'h80000000) ? 32'h80000000 : mag[31:0];
    end else begin
      m = (mag > 48'h7FFFFFFF) ? 32'h7FFFFFFF : mag[31:0];
    end
    return {m, ng ? 32'(-m) : m};
  endfunction

  logic en;
  assign en          = !point_valid || point_ready;
  assign pixel_ready = en;

  // configuration
  logic [31:0] inv_focal_x, inv_focal_y, depth_scale, min_range, max_range;
  logic [15:0] center_x, center_y;
  logic        ray_range_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      inv_focal_x    <= RST_INV_FOCAL_X;
      inv_focal_y    <= RST_INV_FOCAL_Y;
      center_x       <= RST_CENTER_X;
      center_y       <= RST_CENTER_Y;
      depth_scale    <= RST_DEPTH_SCALE;
      min_range      <= RST_MIN_RANGE;
      max_range      <= RST_MAX_RANGE;
      ray_range_mode <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_INV_FOCAL_X:    inv_focal_x    <= cfg_data;
        REG_INV_FOCAL_Y:    inv_focal_y    <= cfg_data;
        REG_CENTER_X:       center_x       <= cfg_data[15:0];
        REG_CENTER_Y:       center_y       <= cfg_data[15:0];
        REG_DEPTH_SCALE:    depth_scale    <= cfg_data;
        REG_MIN_RANGE:      min_range      <= cfg_data;
        REG_MAX_RANGE:      max_range      <= cfg_data;
        REG_RAY_RANGE_MODE: ray_range_mode <= cfg_data[0];
        default:            ;
      endcase
    end
  end

  // stage 0 combinational: grid check, depth scale, pixel offsets
  logic [11:0] u0, v0;
  logic [44:0] uq_prod, vq_prod;
  logic [12:0] uq, vq;
  logic        grid_ok, sample_ok;
  logic [47:0] dprod0;
  logic [15:0] pu0, pv0, dxm0, dym0;
  logic        dxn0, dyn0;

  assign u0        = pixel.column & COORD_MASK;
  assign v0        = pixel.row & COORD_MASK;
  assign uq_prod   = 45'(u0) * 45'(STRIDE_RECIP);
  assign vq_prod   = 45'(v0) * 45'(STRIDE_RECIP);
  assign uq        = uq_prod[44:32];
  assign vq        = vq_prod[44:32];
  assign grid_ok   = (18'(uq) * 18'(GRID_STEP) == 18'(u0)) &&
                     (18'(vq) * 18'(GRID_STEP) == 18'(v0));
  assign sample_ok = pixel.depth_sample != 16'(INVALID_SAMPLE);
  assign dprod0    = 48'(pixel.depth_sample) * 48'(depth_scale);
  assign pu0       = {u0, 4'b0000};
  assign pv0       = {v0, 4'b0000};
  assign dxn0      = pu0 < center_x;
  assign dyn0      = pv0 < center_y;
  assign dxm0      = dxn0 ? center_x - pu0 : pu0 - center_x;
  assign dym0      = dyn0 ? center_y - pv0 : pv0 - center_y;

  // front stages
  logic        v1, v2, v3, v4, v5;
  logic [31:0] d1, d2, d3, d4, d5;
  logic [15:0] dxm1, dym1;
  logic        xn1, yn1, xn2, yn2, xn3, yn3, xn4, yn4, xn5, yn5;
  logic [47:0] px2, py2;
  logic [30:0] rx3, ry3;
  logic [62:0] rxd4, ryd4, rxd5, ryd5;
  logic [61:0] sqx4, sqy4;
  logic [46:0] xz5, yz5;
  logic [63:0] nsum5;
  logic [36:0] rxt, ryt;
  logic [30:0] rxs, rys;

  assign rxt = 37'((49'(px2) + 49'd2048) >> 12);
  assign ryt = 37'((49'(py2) + 49'd2048) >> 12);
  assign rxs = (rxt > 37'h7FFFFFFF) ? 31'h7FFFFFFF : rxt[30:0];
  assign rys = (ryt > 37'h7FFFFFFF) ? 31'h7FFFFFFF : ryt[30:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      {v1, v2, v3, v4, v5} <= '0;
    end else if (en) begin
      v1 <= pixel_valid && grid_ok && sample_ok;
      v2 <= v1 && (d1 != 32'd0);
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d1    <= dprod0[47:16];
      dxm1  <= dxm0;
      dym1  <= dym0;
      xn1   <= dxn0;
      yn1   <= dyn0;
      px2   <= 48'(dxm1) * 48'(inv_focal_x);
      py2   <= 48'(dym1) * 48'(inv_focal_y);
      d2    <= d1;
      xn2   <= xn1;
      yn2   <= yn1;
      rx3   <= rxs;
      ry3   <= rys;
      xn3   <= xn2 && (rxs != 31'd0);
      yn3   <= yn2 && (rys != 31'd0);
      d3    <= d2;
      rxd4  <= 63'(rx3) * 63'(d3);
      ryd4  <= 63'(ry3) * 63'(d3);
      sqx4  <= 62'(rx3) * 62'(rx3);
      sqy4  <= 62'(ry3) * 62'(ry3);
      d4    <= d3;
      xn4   <= xn3;
      yn4   <= yn3;
      xz5   <= 47'((64'(rxd4) + 64'd32768) >> 16);
      yz5   <= 47'((64'(ryd4) + 64'd32768) >> 16);
      nsum5 <= 64'(sqx4) + 64'(sqy4) + (64'd1 << 32);
      rxd5  <= rxd4;
      ryd5  <= ryd4;
      d5    <= d4;
      xn5   <= xn4;
      yn5   <= yn4;
    end
  end

  // ray norm
  logic [31:0] norm;
  dpp_sqrt u_norm_sqrt (.clk(clk), .en(en), .rad(nsum5), .root(norm));

  side_a_t side_a [SQRT_STEPS];
  logic    va     [SQRT_STEPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < SQRT_STEPS; k++) va[k] <= 1'b0;
    end else if (en) begin
      va[0] <= v5;
      for (int k = 1; k < SQRT_STEPS; k++) va[k] <= va[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_a[0] <= '{rxd: rxd5, ryd: ryd5, d: d5, xz: xz5, yz: yz5, xn: xn5, yn: yn5};
      for (int k = 1; k < SQRT_STEPS; k++) side_a[k] <= side_a[k-1];
    end
  end

  // unit ray scaling
  side_a_t sa;
  logic [31:0] qx, qy, qz;
  assign sa = side_a[SQRT_STEPS-1];

  dpp_div u_div_x (.clk(clk), .en(en), .num({1'b0, sa.rxd}), .den({1'b0, norm}), .quo(qx));
  dpp_div u_div_y (.clk(clk), .en(en), .num({1'b0, sa.ryd}), .den({1'b0, norm}), .quo(qy));
  dpp_div u_div_z (.clk(clk), .en(en), .num({16'd0, sa.d, 16'd0}), .den({1'b0, norm}),
                   .quo(qz));

  side_b_t side_b [DIV_STEPS];
  logic    vb     [DIV_STEPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < DIV_STEPS; k++) vb[k] <= 1'b0;
    end else if (en) begin
      vb[0] <= va[SQRT_STEPS-1];
      for (int k = 1; k < DIV_STEPS; k++) vb[k] <= vb[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_b[0] <= '{d: sa.d, xz: sa.xz, yz: sa.yz, xn: sa.xn, yn: sa.yn};
      for (int k = 1; k < DIV_STEPS; k++) side_b[k] <= side_b[k-1];
    end
  end

  // mode select and saturation
  side_b_t sb;
  logic [63:0] satx, saty, satz;
  assign sb   = side_b[DIV_STEPS-1];
  assign satx = sat_coord(ray_range_mode ? 48'(qx) : 48'(sb.xz), sb.xn);
  assign saty = sat_coord(ray_range_mode ? 48'(qy) : 48'(sb.yz), sb.yn);
  assign satz = sat_coord(48'(ray_range_mode ? qz : sb.d), 1'b0);

  logic        v6, v7, v8;
  coord_t      c6, c7, c8;
  logic [31:0] xm6, ym6, zm6;
  logic [63:0] sqx7, sqy7, sqz7, rsum8;

  always_ff @(posedge clk) begin
    if (rst) begin
      {v6, v7, v8} <= '0;
    end else if (en) begin
      v6 <= vb[DIV_STEPS-1];
      v7 <= v6;
      v8 <= v7;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c6    <= '{xb: satx[31:0], yb: saty[31:0], zb: satz[31:0]};
      xm6   <= satx[63:32];
      ym6   <= saty[63:32];
      zm6   <= satz[63:32];
      sqx7  <= 64'(xm6) * 64'(xm6);
      sqy7  <= 64'(ym6) * 64'(ym6);
      sqz7  <= 64'(zm6) * 64'(zm6);
      c7    <= c6;
      rsum8 <= sqx7 + sqy7 + sqz7;
      c8    <= c7;
    end
  end

  // point range
  logic [31:0] range;
  dpp_sqrt u_range_sqrt (.clk(clk), .en(en), .rad(rsum8), .root(range));

  coord_t side_c [SQRT_STEPS];
  logic   vc     [SQRT_STEPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < SQRT_STEPS; k++) vc[k] <= 1'b0;
    end else if (en) begin
      vc[0] <= v8;
      for (int k = 1; k < SQRT_STEPS; k++) vc[k] <= vc[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_c[0] <= c8;
      for (int k = 1; k < SQRT_STEPS; k++) side_c[k] <= side_c[k-1];
    end
  end

  // range window and color numerators
  logic        in_window;
  logic [31:0] span0, span, rel0, rel;
  logic [32:0] two_rel, dev0;

  assign in_window = (range >= min_range) && (range <= max_range);
  assign span0     = max_range - min_range;
  assign span      = (span0 == 32'd0) ? 32'd1 : span0;
  assign rel0      = range - min_range;
  assign rel       = (rel0 > span) ? span : rel0;
  assign two_rel   = {rel, 1'b0};
  assign dev0      = (two_rel >= 33'(span)) ? two_rel - 33'(span) : 33'(span) - two_rel;

  logic        v9, v10;
  coord_t      c9, c10;
  logic [31:0] a9, den9, dev9;
  logic [41:0] nr10, ng10, nb10;
  logic [32:0] dv10;

  always_ff @(posedge clk) begin
    if (rst) begin
      {v9, v10} <= '0;
    end else if (en) begin
      v9  <= vc[SQRT_STEPS-1] && in_window;
      v10 <= v9;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c9   <= side_c[SQRT_STEPS-1];
      a9   <= rel;
      den9 <= span;
      dev9 <= dev0[31:0];
      nr10 <= 42'(a9) * 42'd510 + 42'(den9);
      ng10 <= 42'(den9 - dev9) * 42'd380 + 42'(den9);
      nb10 <= 42'(den9 - a9) * 42'd510 + 42'(den9);
      dv10 <= {den9, 1'b0};
      c10  <= c9;
    end
  end

  logic [31:0] qr, qg, qb;
  dpp_div u_div_red   (.clk(clk), .en(en), .num(64'(nr10)), .den(dv10), .quo(qr));
  dpp_div u_div_green (.clk(clk), .en(en), .num(64'(ng10)), .den(dv10), .quo(qg));
  dpp_div u_div_blue  (.clk(clk), .en(en), .num(64'(nb10)), .den(dv10), .quo(qb));

  coord_t side_d [DIV_STEPS];
  logic   vd     [DIV_STEPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < DIV_STEPS; k++) vd[k] <= 1'b0;
    end else if (en) begin
      vd[0] <= v10;
      for (int k = 1; k < DIV_STEPS; k++) vd[k] <= vd[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_d[0] <= c10;
      for (int k = 1; k < DIV_STEPS; k++) side_d[k] <= side_d[k-1];
    end
  end

  // output register
  coord_t cd;
  assign cd = side_d[DIV_STEPS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      point_valid <= 1'b0;
    end else if (en) begin
      point_valid <= vd[DIV_STEPS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      point.point_x <= cd.xb;
      point.point_y <= cd.yb;
      point.point_z <= cd.zb;
      point.red     <= qr[7:0];
      point.green   <= qg[7:0] + 8'd35;
      point.blue    <= qb[7:0];
    end
  end

  // checks
  a_reset_empty: assert property (@(posedge clk) !rst && $past(rst) |-> !point_valid)
    else $error("point valid right after reset");

  a_green_floor: assert property (@(posedge clk) disable iff (rst)
    point_valid |-> point.green >= 8'd35)
    else $error("green below ramp floor");

  a_z_nonneg: assert property (@(posedge clk) disable iff (rst)
    point_valid |-> !point.point_z[31])
    else $error("negative z on output");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !pixel_ready |=> $stable(vd[DIV_STEPS-1]) && $stable(v10))
    else $error("pipeline moved during stall");

endmodule
